@@ design/vtpg_pkg.sv @@
package vtpg_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int COORD_W     = 12;
  localparam int FRAME_W     = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int DIM_CFG_W   = 13;
  localparam int CSIZE_W     = 12;

  // reciprocal of 7, exact for floor(w / 7) up to 16384
  localparam int                REC7_W  = 18;
  localparam int                REC7_SH = 20;
  localparam logic [REC7_W-1:0] REC7    = 18'd149797;

  localparam logic [CSIZE_W-1:0] CHECK_DEF = 12'd16;
  localparam logic [7:0]         GREY_HI   = 8'hE0;
  localparam logic [7:0]         GREY_LO   = 8'h20;
  localparam logic [7:0]         BAR_ON    = 8'hEB;

  localparam logic [31:0] HASH_KX = 32'h1E35A7BD;
  localparam logic [31:0] HASH_KY = 32'h94D049BB;
  localparam logic [31:0] HASH_KF = 32'hD1B54A35;
  localparam logic [31:0] HASH_K0 = 32'h9E3779B9;
  localparam logic [31:0] HASH_M1 = 32'h85EBCA6B;
  localparam logic [31:0] HASH_M2 = 32'hC2B2AE35;

  // unit latencies, counted from the input register
  localparam int HASH_LAT = 5;
  localparam int RAD_LAT  = 13;
  localparam int DIV_LAT  = COORD_W;
  localparam int ALIGN    = FRAME_W + 2;
  // accept edge to the edge that takes the result
  localparam int PIPE_LAT = FRAME_W + 5;

  typedef enum logic [2:0] {
    MODE_RAMP    = 3'd0,
    MODE_SOLID   = 3'd1,
    MODE_CHECK   = 3'd2,
    MODE_BARS    = 3'd3,
    MODE_RADIAL  = 3'd4,
    MODE_CORNERS = 3'd5,
    MODE_NOISE   = 3'd6,
    MODE_ANIM    = 3'd7
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 3'd0,
    CFG_WIDTH   = 3'd1,
    CFG_HEIGHT  = 3'd2,
    CFG_SOLID   = 3'd3,
    CFG_CHECK   = 3'd4,
    CFG_SEED    = 3'd5,
    CFG_ORDER   = 3'd6,
    CFG_OVERLAY = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [FRAME_W-1:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } out_item_t;

  // returns {b, g, r}
  function automatic logic [23:0] bar_rgb(input logic [2:0] idx);
    logic [23:0] c;
    case (idx)
      3'd0:    c = {BAR_ON, BAR_ON, BAR_ON};
      3'd1:    c = {8'h00,  BAR_ON, BAR_ON};
      3'd2:    c = {BAR_ON, BAR_ON, 8'h00};
      3'd3:    c = {8'h00,  BAR_ON, 8'h00};
      3'd4:    c = {BAR_ON, 8'h00,  BAR_ON};
      3'd5:    c = {8'h00,  8'h00,  BAR_ON};
      default: c = {BAR_ON, 8'h00,  8'h00};
    endcase
    return c;
  endfunction

endpackage

@@ design/vtpg_delay.sv @@
module vtpg_delay
  import vtpg_pkg::*;
#(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    sr_r[0] <= d_i;
    for (int i = 1; i < N; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign q_o = sr_r[N-1];

endmodule

@@ design/vtpg_div.sv @@
// restoring divider, one quotient bit per stage
module vtpg_div
  import vtpg_pkg::*;
#(
  parameter int NW  = 12,
  parameter int DDW = 12
) (
  input  logic           clk,
  input  logic [NW-1:0]  num_i,
  input  logic [DDW-1:0] den_i,
  output logic [NW-1:0]  quo_o,
  output logic [DDW-1:0] rem_o
);

  logic [NW-1:0]  num_r [NW];
  logic [NW-1:0]  quo_r [NW];
  logic [DDW-1:0] rem_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [NW-1:0]  num_in;
    logic [NW-1:0]  quo_in;
    logic [DDW-1:0] rem_in;
    logic [DDW:0]   trial;
    logic           fits;

    if (i == 0) begin : g_first
      assign num_in = num_i;
      assign quo_in = '0;
      assign rem_in = '0;
    end else begin : g_next
      assign num_in = num_r[i-1];
      assign quo_in = quo_r[i-1];
      assign rem_in = rem_r[i-1];
    end

    assign trial = {rem_in, num_in[NW-1]};
    assign fits  = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      num_r[i] <= num_in << 1;
      quo_r[i] <= {quo_in[NW-2:0], fits};
      rem_r[i] <= fits ? DDW'(trial - {1'b0, den_i}) : trial[DDW-1:0];
    end
  end

  assign quo_o = quo_r[NW-1];
  assign rem_o = rem_r[NW-1];

endmodule

@@ design/vtpg_radial.sv @@
// radial gradient level t = min(255, r2*255 / maxr2)
module vtpg_radial
  import vtpg_pkg::*;
#(
  parameter int DW = 13
) (
  input  logic               clk,
  input  logic [COORD_W-1:0] x_i,
  input  logic [COORD_W-1:0] y_i,
  input  logic [DW-1:0]      w_i,
  input  logic [DW-1:0]      h_i,
  output logic [7:0]         t_o
);

  localparam int PW  = (DW > COORD_W) ? DW : COORD_W;
  localparam int SW  = 2 * PW + 1;
  localparam int NRW = SW + 8;
  localparam int CXW = DW - 1;
  localparam int MRW = 2 * CXW + 1;
  localparam int QB  = 9;

  logic [CXW-1:0]   cx, cy;
  logic [2*CXW-1:0] cx2_r, cy2_r;
  logic [MRW-1:0]   msum, maxr2_r;

  assign cx   = CXW'(w_i >> 1);
  assign cy   = CXW'(h_i >> 1);
  assign msum = MRW'(cx2_r) + MRW'(cy2_r);

  // frame constants, settled long before an item reaches the divide steps
  always_ff @(posedge clk) begin
    cx2_r   <= (2*CXW)'(cx) * (2*CXW)'(cx);
    cy2_r   <= (2*CXW)'(cy) * (2*CXW)'(cy);
    maxr2_r <= (msum == '0) ? MRW'(1) : msum;
  end

  logic [PW-1:0]   xp, yp, cxp, cyp;
  logic [PW-1:0]   dx_r, dy_r;
  logic [2*PW-1:0] sx_r, sy_r;
  logic [SW-1:0]   r2_r;
  logic [NRW-1:0]  n_r;

  assign xp  = PW'(x_i);
  assign yp  = PW'(y_i);
  assign cxp = PW'(cx);
  assign cyp = PW'(cy);

  always_ff @(posedge clk) begin
    dx_r <= (xp >= cxp) ? (xp - cxp) : (cxp - xp);
    dy_r <= (yp >= cyp) ? (yp - cyp) : (cyp - yp);
    sx_r <= (2*PW)'(dx_r) * (2*PW)'(dx_r);
    sy_r <= (2*PW)'(dy_r) * (2*PW)'(dy_r);
    r2_r <= SW'(sx_r) + SW'(sy_r);
    n_r  <= (NRW'(r2_r) << 8) - NRW'(r2_r);
  end

  // top step is the saturation test against maxr2 * 256
  logic [NRW-1:0] rem_r [QB];
  logic [QB-1:0]  q_r   [QB];

  for (genvar i = 0; i < QB; i++) begin : g_st
    logic [NRW-1:0] rem_in;
    logic [QB-1:0]  q_in;
    logic [NRW-1:0] sh;
    logic           fits;

    if (i == 0) begin : g_first
      assign rem_in = n_r;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign sh   = NRW'(maxr2_r) << (QB - 1 - i);
    assign fits = (rem_in >= sh);

    always_ff @(posedge clk) begin
      rem_r[i] <= fits ? (rem_in - sh) : rem_in;
      q_r[i]   <= {q_in[QB-2:0], fits};
    end
  end

  assign t_o = q_r[QB-1][QB-1] ? 8'hFF : q_r[QB-1][7:0];

endmodule

@@ design/vtpg_hash.sv @@
// per-pixel noise hash
module vtpg_hash
  import vtpg_pkg::*;
(
  input  logic               clk,
  input  logic [31:0]        seed_i,
  input  logic [COORD_W-1:0] x_i,
  input  logic [COORD_W-1:0] y_i,
  input  logic [FRAME_W-1:0] phase_i,
  output logic [31:0]        h_o
);

  logic [31:0] px_r, py_r, pf_r;
  logic [31:0] s2_r, s3_r, s4_r, s5_r;
  logic [31:0] v_a, v_b, s3_x;

  assign v_a  = (seed_i ^ px_r ^ py_r ^ pf_r) + HASH_K0;
  assign v_b  = v_a ^ (v_a >> 16);
  assign s3_x = s3_r ^ (s3_r >> 13);

  always_ff @(posedge clk) begin
    px_r <= 32'(x_i) * HASH_KX;
    py_r <= 32'(y_i) * HASH_KY;
    pf_r <= phase_i * HASH_KF;
    s2_r <= v_b;
    s3_r <= s2_r * HASH_M1;
    s4_r <= s3_x * HASH_M2;
    s5_r <= s4_r ^ (s4_r >> 16);
  end

  assign h_o = s5_r;

endmodule

@@ design/video_test_pattern_generator_unit.sv @@
// Video test pattern generator: one pixel (x, y, frame number) in, four
// packed bytes out.
// Input: an item is taken at a clock edge with start high and busy low.
// busy is low at all times outside reset, so an item may enter every cycle.
// Output: out_strobe marks out_data for one cycle; the receiver cannot
// stall the block and every item yields exactly one result, in order.
// The slowest unit is the column overlay's (4*frame) mod width, a 34-stage
// bit-serial remainder pipeline. The other units (checker and bar dividers,
// radial divide, noise hash) are shorter and are delayed to line up with it.
// Throughput: one pixel per clock.
// Configuration: cfg_we writes register cfg_index with cfg_wdata at once;
// write only while no item is in flight.
// Reset (rst_n low, synchronous): configuration registers go to their
// defaults, items in flight are dropped and busy is high.
module video_test_pattern_generator_unit
  import vtpg_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_strobe,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int MW = ((DW > COORD_W) ? DW : COORD_W) + 1;

  // ---------------- configuration ----------------
  mode_t                mode_r;
  logic [DIM_CFG_W-1:0] fw_r, fh_r;
  logic [31:0]          solid_r, seed_r;
  logic [CSIZE_W-1:0]   csize_r;
  logic                 order_r;
  logic [1:0]           ovl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RAMP;
      fw_r    <= 13'd640;
      fh_r    <= 13'd480;
      solid_r <= 32'hFF000000;
      csize_r <= CHECK_DEF;
      seed_r  <= '0;
      order_r <= 1'b0;
      ovl_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:    mode_r  <= mode_t'(cfg_wdata[2:0]);
        CFG_WIDTH:   fw_r    <= cfg_wdata[DIM_CFG_W-1:0];
        CFG_HEIGHT:  fh_r    <= cfg_wdata[DIM_CFG_W-1:0];
        CFG_SOLID:   solid_r <= cfg_wdata;
        CFG_CHECK:   csize_r <= cfg_wdata[CSIZE_W-1:0];
        CFG_SEED:    seed_r  <= cfg_wdata;
        CFG_ORDER:   order_r <= cfg_wdata[0];
        CFG_OVERLAY: ovl_r   <= cfg_wdata[1:0];
      endcase
    end
  end

  logic [DW-1:0]      w, h;
  logic [CSIZE_W-1:0] step;

  always_comb begin
    if (fw_r == '0)                w = DW'(1);
    else if (32'(fw_r) > MAX_DIM)  w = DW'(MAX_DIM);
    else                           w = DW'(fw_r);
    if (fh_r == '0)                h = DW'(1);
    else if (32'(fh_r) > MAX_DIM)  h = DW'(MAX_DIM);
    else                           h = DW'(fh_r);
  end

  assign step = (csize_r == '0) ? CHECK_DEF : csize_r;

  // bar width = max(1, w / 7)
  logic [DW+REC7_W-1:0] bw_prod_r, bw_sh;
  logic [DW-1:0]        bw_r;

  assign bw_sh = bw_prod_r >> REC7_SH;

  always_ff @(posedge clk) begin
    bw_prod_r <= {{REC7_W{1'b0}}, w} * {{DW{1'b0}}, REC7};
    bw_r      <= (DW'(bw_sh) == '0) ? DW'(1) : DW'(bw_sh);
  end

  // ---------------- input stage ----------------
  logic               accept;
  logic [PIPE_LAT-1:0] vld_r;
  logic [COORD_W-1:0] x0_r, y0_r;
  logic [FRAME_W-1:0] f0_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x0_r <= in_data.pixel_x;
      y0_r <= in_data.pixel_y;
      f0_r <= in_data.frame_number;
    end
  end

  // ---------------- units ----------------
  logic [DW-1:0] col;

  vtpg_div #(.NW(FRAME_W + 2), .DDW(DW)) u_col (
    .clk   (clk),
    .num_i ({f0_r, 2'b00}),
    .den_i (w),
    .quo_o (),
    .rem_o (col)
  );

  logic [COORD_W-1:0] qx, qy;

  vtpg_div #(.NW(COORD_W), .DDW(CSIZE_W)) u_chk_x (
    .clk   (clk),
    .num_i (x0_r),
    .den_i (step),
    .quo_o (qx),
    .rem_o ()
  );

  vtpg_div #(.NW(COORD_W), .DDW(CSIZE_W)) u_chk_y (
    .clk   (clk),
    .num_i (y0_r),
    .den_i (step),
    .quo_o (qy),
    .rem_o ()
  );

  logic par_a;

  vtpg_delay #(.W(1), .N(ALIGN - DIV_LAT)) u_dly_par (
    .clk (clk),
    .d_i (qx[0] ^ qy[0]),
    .q_o (par_a)
  );

  // bar divider starts two stages late so bw_r has settled after a write
  logic [COORD_W-1:0] x2;
  logic [COORD_W-1:0] bq;
  logic [2:0]         bidx, bidx_a;

  vtpg_delay #(.W(COORD_W), .N(2)) u_dly_bx (
    .clk (clk),
    .d_i (x0_r),
    .q_o (x2)
  );

  vtpg_div #(.NW(COORD_W), .DDW(DW)) u_bar (
    .clk   (clk),
    .num_i (x2),
    .den_i (bw_r),
    .quo_o (bq),
    .rem_o ()
  );

  assign bidx = (bq > COORD_W'(6)) ? 3'd6 : bq[2:0];

  vtpg_delay #(.W(3), .N(ALIGN - 2 - DIV_LAT)) u_dly_bar (
    .clk (clk),
    .d_i (bidx),
    .q_o (bidx_a)
  );

  logic [7:0] rt, rt_a;

  vtpg_radial #(.DW(DW)) u_rad (
    .clk (clk),
    .x_i (x0_r),
    .y_i (y0_r),
    .w_i (w),
    .h_i (h),
    .t_o (rt)
  );

  vtpg_delay #(.W(8), .N(ALIGN - RAD_LAT)) u_dly_rad (
    .clk (clk),
    .d_i (rt),
    .q_o (rt_a)
  );

  logic [FRAME_W-1:0] phase;
  logic [31:0]        hv;
  logic [23:0]        hv_a;

  assign phase = (mode_r == MODE_ANIM) ? f0_r : '0;

  vtpg_hash u_hash (
    .clk     (clk),
    .seed_i  (seed_r),
    .x_i     (x0_r),
    .y_i     (y0_r),
    .phase_i (phase),
    .h_o     (hv)
  );

  vtpg_delay #(.W(24), .N(ALIGN - HASH_LAT)) u_dly_hash (
    .clk (clk),
    .d_i (hv[23:0]),
    .q_o (hv_a)
  );

  logic [COORD_W-1:0] xa, ya;
  logic [FRAME_W-1:0] fa;

  vtpg_delay #(.W(2 * COORD_W + FRAME_W), .N(ALIGN)) u_dly_pix (
    .clk (clk),
    .d_i ({x0_r, y0_r, f0_r}),
    .q_o ({xa, ya, fa})
  );

  // ---------------- base color ----------------
  logic [MW-1:0] xe, ye, we, he, cw, ch;
  logic          in_frame;
  logic [7:0]    r_nxt, g_nxt, b_nxt, a_nxt, rv, gv;
  logic [9:0]    rv3;
  logic [23:0]   bar_c;
  logic [31:0]   base_r;
  logic          hit_r;
  logic [9:0]    fa_r;

  assign xe       = MW'(xa);
  assign ye       = MW'(ya);
  assign we       = MW'(w);
  assign he       = MW'(h);
  assign cw       = ((we >> 3) == '0) ? MW'(1) : (we >> 3);
  assign ch       = ((he >> 3) == '0) ? MW'(1) : (he >> 3);
  assign in_frame = (xe < we) && (ye < he);
  assign rv       = 8'hFF - rt_a;
  assign rv3      = {2'b00, rv} + {1'b0, rv, 1'b0};
  assign gv       = rv3[9:2];
  assign bar_c    = bar_rgb(bidx_a);

  always_comb begin
    a_nxt = 8'hFF;
    unique case (mode_r)
      MODE_RAMP: begin
        r_nxt = xa[7:0];
        g_nxt = ya[7:0];
        b_nxt = xa[7:0] ^ ya[7:0];
      end
      MODE_SOLID: begin
        {a_nxt, b_nxt, g_nxt, r_nxt} = solid_r;
      end
      MODE_CHECK: begin
        r_nxt = par_a ? GREY_HI : GREY_LO;
        g_nxt = r_nxt;
        b_nxt = r_nxt;
      end
      MODE_BARS: begin
        {b_nxt, g_nxt, r_nxt} = bar_c;
      end
      MODE_RADIAL: begin
        r_nxt = rv;
        g_nxt = gv;
        b_nxt = rt_a;
      end
      MODE_CORNERS: begin
        priority if (xe == (we >> 1) || ye == (he >> 1)) begin
          {b_nxt, g_nxt, r_nxt} = {8'h00, 8'hFF, 8'hFF};
        end else if (in_frame && (xe == '0 || ye == '0 || xe == we - 1'b1 ||
                                  ye == he - 1'b1)) begin
          {b_nxt, g_nxt, r_nxt} = {8'hFF, 8'hFF, 8'hFF};
        end else if (in_frame && xe >= we - cw && ye >= he - ch) begin
          {b_nxt, g_nxt, r_nxt} = {8'hFF, 8'hFF, 8'hFF};
        end else if (in_frame && xe < cw && ye >= he - ch) begin
          {b_nxt, g_nxt, r_nxt} = {8'hFF, 8'h00, 8'h00};
        end else if (in_frame && xe >= we - cw && ye < ch) begin
          {b_nxt, g_nxt, r_nxt} = {8'h00, 8'hFF, 8'h00};
        end else if (in_frame && xe < cw && ye < ch) begin
          {b_nxt, g_nxt, r_nxt} = {8'h00, 8'h00, 8'hFF};
        end else begin
          {a_nxt, b_nxt, g_nxt, r_nxt} = solid_r;
        end
      end
      MODE_NOISE, MODE_ANIM: begin
        {b_nxt, g_nxt, r_nxt} = hv_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    base_r <= {a_nxt, b_nxt, g_nxt, r_nxt};
    hit_r  <= (xe == MW'(col));
    fa_r   <= fa[9:0];
  end

  // ---------------- overlays and packing ----------------
  logic [7:0] r_o, g_o, b_o, a_o;
  out_item_t  out_nxt, out_r;

  always_comb begin
    {a_o, b_o, g_o, r_o} = base_r;
    if (ovl_r[0]) begin
      r_o = r_o + fa_r[7:0];
      g_o = g_o + fa_r[8:1];
      b_o = b_o + fa_r[9:2];
    end
    if (ovl_r[1] && hit_r) begin
      {a_o, b_o, g_o, r_o} = 32'hFFFFFFFF;
    end
    out_nxt.byte0 = order_r ? b_o : r_o;
    out_nxt.byte1 = g_o;
    out_nxt.byte2 = order_r ? r_o : b_o;
    out_nxt.byte3 = a_o;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data   = out_r;
  assign out_strobe = vld_r[PIPE_LAT-1];

endmodule

@@ design/vtpg_checker.sv @@
module vtpg_checker
  import vtpg_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy high outside reset");

  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_strobe)
    else $error("accepted item gave no result at the fixed latency");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LAT))
    else $error("result with no matching item");

endmodule

bind video_test_pattern_generator_unit vtpg_checker u_vtpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);
